// File: rtl/core/time_of_day_text_parser_defines.svh
// Assertion macros for the time-of-day text parser.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef TIME_OF_DAY_TEXT_PARSER_DEFINES_SVH
`define TIME_OF_DAY_TEXT_PARSER_DEFINES_SVH
`ifndef SYNTH
// Check that prop holds at every clock edge outside reset.
`define TDP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that cons holds in the cycle after ante.
`define TDP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TDP_ASSERT(label, clk, rst, prop, msg)
`define TDP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: rtl/core/tdp_pkg.sv
// Shared types and constants for the time-of-day text parser.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package tdp_pkg;

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  localparam logic [7:0] HOUR_LIMIT   = 8'd23;
  localparam logic [9:0] MINSEC_LIMIT = 10'd59;

  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;

  typedef enum logic [5:0] {
    PH_WS   = 6'b000001,
    PH_HOUR = 6'b000010,
    PH_MIN  = 6'b000100,
    PH_SEC  = 6'b001000,
    PH_DONE = 6'b010000,
    PH_FAIL = 6'b100000
  } tdp_phase_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } tdp_in_t;

  typedef struct packed {
    logic        valid_res;
    logic [16:0] day_seconds;
    logic [4:0]  hour_value;
    logic [5:0]  minute_value;
    logic [5:0]  second_value;
  } tdp_out_t;

  // Handshake between the input stage and the parse core.
  typedef struct packed {
    logic    valid;
    tdp_in_t data;
  } tdp_byte_t;

endpackage

// File: rtl/core/tdp_in_stage.sv
// Input register of the time-of-day text parser: holds one byte transaction.
// Depends on tdp_pkg.
`timescale 1ns / 1ps

module tdp_in_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             valid,
  output logic             ready,
  input  tdp_pkg::tdp_in_t data,
  input  logic             take,
  output tdp_pkg::tdp_byte_t held
);

  logic             held_valid;
  tdp_pkg::tdp_in_t held_data;

  assign ready = !held_valid || take;
  assign held  = '{valid: held_valid, data: held_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (valid && ready) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (valid && ready) begin
      held_data <= data;
    end
  end

endmodule

// File: rtl/core/tdp_parse_core.sv
// Parse state and per-byte next-state logic of the time-of-day text parser.
// Depends on tdp_pkg.
`timescale 1ns / 1ps

module tdp_parse_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  tdp_pkg::tdp_in_t  byte_in,
  output logic              res_fire,
  output tdp_pkg::tdp_out_t res
);

  tdp_pkg::tdp_phase_t phase, phase_next, phase_eff;
  logic [4:0] hour_acc, hour_acc_next;
  logic [5:0] minute_acc, minute_acc_next;
  logic [5:0] second_acc, second_acc_next;

  logic       is_blank, is_digit, is_colon;
  logic [3:0] digit;
  logic [7:0] hour_cand;
  logic [9:0] minute_cand, second_cand;
  logic       time_ok;

  always_comb begin
    is_blank = byte_in.char_code inside {tdp_pkg::CHAR_SPACE,
                                         [tdp_pkg::CHAR_TAB:tdp_pkg::CHAR_CR]};
    is_digit = byte_in.char_code inside {[tdp_pkg::CHAR_ZERO:tdp_pkg::CHAR_NINE]};
    is_colon = (byte_in.char_code == tdp_pkg::CHAR_COLON);
    digit    = byte_in.char_code[3:0];

    hour_cand   = {3'd0, hour_acc} * 8'd10 + {4'd0, digit};
    minute_cand = {4'd0, minute_acc} * 10'd10 + {6'd0, digit};
    second_cand = {4'd0, second_acc} * 10'd10 + {6'd0, digit};

    // First non-blank byte starts the hour field in the same cycle.
    phase_eff = (phase == tdp_pkg::PH_WS && !is_blank) ? tdp_pkg::PH_HOUR : phase;

    phase_next      = phase_eff;
    hour_acc_next   = hour_acc;
    minute_acc_next = minute_acc;
    second_acc_next = second_acc;

    case (phase_eff)
      tdp_pkg::PH_WS, tdp_pkg::PH_DONE: begin
      end
      tdp_pkg::PH_HOUR: begin
        if (is_digit) begin
          if (hour_cand > tdp_pkg::HOUR_LIMIT) phase_next = tdp_pkg::PH_FAIL;
          else hour_acc_next = hour_cand[4:0];
        end else if (is_colon) begin
          phase_next = tdp_pkg::PH_MIN;
        end else begin
          phase_next = tdp_pkg::PH_FAIL;
        end
      end
      tdp_pkg::PH_MIN: begin
        if (is_digit) begin
          if (minute_cand > tdp_pkg::MINSEC_LIMIT) phase_next = tdp_pkg::PH_FAIL;
          else minute_acc_next = minute_cand[5:0];
        end else if (is_colon) begin
          phase_next = tdp_pkg::PH_SEC;
        end else begin
          phase_next = tdp_pkg::PH_FAIL;
        end
      end
      tdp_pkg::PH_SEC: begin
        if (is_digit) begin
          if (second_cand > tdp_pkg::MINSEC_LIMIT) phase_next = tdp_pkg::PH_FAIL;
          else second_acc_next = second_cand[5:0];
        end else begin
          phase_next = tdp_pkg::PH_DONE;
        end
      end
      default: begin
        phase_next = tdp_pkg::PH_FAIL;
      end
    endcase

    time_ok  = (phase_next == tdp_pkg::PH_SEC) || (phase_next == tdp_pkg::PH_DONE);
    res_fire = step && byte_in.last_char;

    if (time_ok) begin
      res.valid_res    = 1'b1;
      res.hour_value   = hour_acc_next;
      res.minute_value = minute_acc_next;
      res.second_value = second_acc_next;
      res.day_seconds  = {12'd0, hour_acc_next} * tdp_pkg::SECS_PER_HOUR
                       + {11'd0, minute_acc_next} * tdp_pkg::SECS_PER_MIN
                       + {11'd0, second_acc_next};
    end else begin
      res = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= tdp_pkg::PH_WS;
      hour_acc   <= '0;
      minute_acc <= '0;
      second_acc <= '0;
    end else if (step) begin
      if (byte_in.last_char) begin
        // End of string: drop back to the start state for the next one.
        phase      <= tdp_pkg::PH_WS;
        hour_acc   <= '0;
        minute_acc <= '0;
        second_acc <= '0;
      end else begin
        phase      <= phase_next;
        hour_acc   <= hour_acc_next;
        minute_acc <= minute_acc_next;
        second_acc <= second_acc_next;
      end
    end
  end

endmodule

// File: rtl/core/tdp_out_stage.sv
// Result register of the time-of-day text parser: holds one result transaction.
// Depends on tdp_pkg.
`timescale 1ns / 1ps

module tdp_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  tdp_pkg::tdp_out_t res,
  output logic              free,
  output logic              valid,
  input  logic              ready,
  output tdp_pkg::tdp_out_t data
);

  assign free = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

endmodule

// File: rtl/core/time_of_day_text_parser.sv
// Time-of-day text parser: streams an HH:MM:SS string one byte per transaction
// and returns one result transaction per string. Depends on tdp_pkg and the defines header.
`timescale 1ns / 1ps
`include "time_of_day_text_parser_defines.svh"

// The block takes one byte per cycle on the char channel while char_ready is high;
// the byte that carries last_char closes the string and yields exactly one result
// on the time channel. time_valid rises once that byte has passed through the input
// register and then been loaded into the result register.
// Leading blanks (tab through carriage return, and space) are skipped; then come
// hour digits, a colon, minute digits, a colon and second digits, each field
// possibly empty (reads as zero). Hour above 23, minute or second above 59, a
// missing colon, or an end before the second colon gives valid_res = 0 with all
// other fields zero. Bytes after the seconds field are ignored. Sustained rate is
// one byte per cycle; the only thing that holds bytes back is a last byte whose
// result cannot enter the result register because an earlier result still waits
// there. Ordinary bytes keep flowing while a result waits to be taken.
module time_of_day_text_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              char_valid,
  output logic              char_ready,
  input  tdp_pkg::tdp_in_t  char_data,
  output logic              time_valid,
  input  logic              time_ready,
  output tdp_pkg::tdp_out_t time_data
);

  tdp_pkg::tdp_byte_t held;
  tdp_pkg::tdp_out_t  res;
  logic               take;
  logic               res_fire;
  logic               out_free;
  logic               res_inv_zero;
  logic               res_in_range;
  logic               res_secs_match;

  // Advance the held byte unless it closes a string and the result slot is full.
  assign take = held.valid && (!held.data.last_char || out_free);

  tdp_in_stage u_in_stage (
    .clk   (clk),
    .rst   (rst),
    .valid (char_valid),
    .ready (char_ready),
    .data  (char_data),
    .take  (take),
    .held  (held)
  );

  // Parse state updates once per byte that leaves the input register.
  tdp_parse_core u_parse_core (
    .clk      (clk),
    .rst      (rst),
    .step     (take),
    .byte_in  (held.data),
    .res_fire (res_fire),
    .res      (res)
  );

  tdp_out_stage u_out_stage (
    .clk   (clk),
    .rst   (rst),
    .load  (res_fire),
    .res   (res),
    .free  (out_free),
    .valid (time_valid),
    .ready (time_ready),
    .data  (time_data)
  );

  // Field checks on the result register, used by the assertions below.
  assign res_inv_zero   = time_data.valid_res || (time_data == '0);
  assign res_in_range   = !time_data.valid_res
                       || ((time_data.hour_value <= 5'd23)
                        && (time_data.minute_value <= 6'd59)
                        && (time_data.second_value <= 6'd59));
  assign res_secs_match = !time_data.valid_res
                       || (time_data.day_seconds ==
                           {12'd0, time_data.hour_value} * tdp_pkg::SECS_PER_HOUR
                         + {11'd0, time_data.minute_value} * tdp_pkg::SECS_PER_MIN
                         + {11'd0, time_data.second_value});

  `TDP_ASSERT(a_invalid_zero, clk, rst, !time_valid || res_inv_zero, "invalid result not zero")
  `TDP_ASSERT(a_valid_range, clk, rst, !time_valid || res_in_range, "valid result out of range")
  `TDP_ASSERT(a_day_seconds, clk, rst, !time_valid || res_secs_match, "day_seconds mismatch")
  `TDP_ASSERT_NEXT(a_last_loads, clk, rst, res_fire, time_valid, "closing byte gave no result")

endmodule
